[hdl/arp_pkg.sv]
// Shared types, constants and the arctangent table for the armor ring block.
// Used by every module of the block; depends on nothing.
package arp_pkg;

	localparam int CordicSteps = 16;
	localparam int AngW = 16;
	localparam int PosW = 24;
	localparam int RadW = 23;
	localparam int CordW = 34;
	localparam int ZW = 34;
	localparam int ProdW = CordW + RadW + 1;

	localparam logic signed [AngW-1:0] PiQ = 16'sd25736;
	localparam logic signed [AngW-1:0] HalfPiQ = 16'sd12868;
	localparam logic signed [17:0] TwoPiQ = 18'sd51472;
	localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
	localparam logic signed [PosW-1:0] PosMax = 24'sd8388607;
	localparam logic signed [PosW-1:0] PosMin = -24'sd8388608;

	localparam logic [2:0] IdxCount = 3'd0;
	localparam logic [2:0] IdxCalib = 3'd1;
	localparam logic [2:0] IdxOffs0 = 3'd2;
	localparam logic [2:0] IdxOffs1 = 3'd3;
	localparam logic [2:0] IdxOffs2 = 3'd4;

	typedef enum logic [1:0] {
		LAYOUT_TWO,
		LAYOUT_THREE,
		LAYOUT_FOUR
	} layout_t;

	// Per-plate payload as it enters the cosine/sine pipeline.
	typedef struct packed {
		logic signed [PosW-1:0] cx;
		logic signed [PosW-1:0] cy;
		logic signed [PosW-1:0] pz;
		logic signed [AngW-1:0] ang;
		logic [RadW-1:0] rad;
		logic outward;
		logic [1:0] idx;
		logic last;
	} plate_t;

	function automatic logic signed [ZW-1:0] atan_q(input int i);
		case (i)
			0: atan_q = 34'sd210828714;
			1: atan_q = 34'sd124459457;
			2: atan_q = 34'sd65760959;
			3: atan_q = 34'sd33381290;
			4: atan_q = 34'sd16755422;
			5: atan_q = 34'sd8385879;
			6: atan_q = 34'sd4193963;
			7: atan_q = 34'sd2097109;
			8: atan_q = 34'sd1048571;
			9: atan_q = 34'sd524287;
			10: atan_q = 34'sd262144;
			11: atan_q = 34'sd131072;
			12: atan_q = 34'sd65536;
			13: atan_q = 34'sd32768;
			14: atan_q = 34'sd16384;
			15: atan_q = 34'sd8192;
			16: atan_q = 34'sd4096;
			17: atan_q = 34'sd2048;
			18: atan_q = 34'sd1024;
			19: atan_q = 34'sd512;
			20: atan_q = 34'sd256;
			21: atan_q = 34'sd128;
			22: atan_q = 34'sd64;
			23: atan_q = 34'sd32;
			default: atan_q = '0;
		endcase
	endfunction

	function automatic logic signed [PosW-1:0] sat_pos(input logic signed [PosW+1:0] v);
		if (v > $signed({{2{1'b0}}, PosMax})) begin
			sat_pos = PosMax;
		end else if (v < $signed({{2{1'b1}}, PosMin})) begin
			sat_pos = PosMin;
		end else begin
			sat_pos = v[PosW-1:0];
		end
	endfunction

endpackage

[hdl/arp_sequencer.sv]
// Expands one target estimate into one plate per cycle, unless the output
// stalls, and wraps each angle. Depends on arp_pkg.
module arp_sequencer import arp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [PosW-1:0] center_x,
	input  logic signed [PosW-1:0] center_y,
	input  logic signed [PosW-1:0] center_z,
	input  logic signed [AngW-1:0] yaw_angle,
	input  logic [RadW-1:0] ring_radius,
	input  logic [RadW-1:0] alt_radius,
	input  logic signed [PosW-1:0] height_term,
	input  logic signed [PosW-1:0] alt_height_offset,
	input  logic [2:0] cnt_cfg,
	input  logic calib_cfg,
	input  logic signed [AngW-1:0] offs0_cfg,
	input  logic signed [AngW-1:0] offs1_cfg,
	input  logic signed [AngW-1:0] offs2_cfg,
	input  logic adv,
	output logic vld_s1,
	output plate_t plate_s1
);

	// Held estimate while its plates are issued.
	logic busy_q;
	logic [1:0] idx_q;
	logic [1:0] last_q;
	layout_t lay_q;
	logic signed [PosW-1:0] cx_q, cy_q, cz_q, ht_q, ah_q;
	logic signed [AngW-1:0] yaw_q;
	logic [RadW-1:0] r0_q, r1_q;

	layout_t lay_in;
	logic [1:0] last_in;
	logic take;

	always_comb begin
		if (cnt_cfg == 3'd3) begin
			lay_in = LAYOUT_THREE;
			last_in = calib_cfg ? 2'd2 : 2'd0;
		end else if (cnt_cfg < 3'd3) begin
			lay_in = LAYOUT_TWO;
			last_in = 2'd1;
		end else begin
			lay_in = LAYOUT_FOUR;
			last_in = 2'd3;
		end
	end

	// A plate enters the issue register whenever it is empty or moving on.
	logic issue;
	assign issue = busy_q && (!vld_s1 || adv);
	assign in_stall = busy_q;
	assign take = in_valid && !busy_q;

	logic signed [17:0] step;
	logic signed [17:0] a_raw;
	logic signed [17:0] a_w;
	logic alt;
	logic signed [PosW:0] dz;

	always_comb begin
		alt = (lay_q == LAYOUT_FOUR) && idx_q[0];
		case (lay_q)
			LAYOUT_THREE: begin
				case (idx_q)
					2'd0: step = 18'(offs0_cfg);
					2'd1: step = 18'(offs1_cfg);
					default: step = 18'(offs2_cfg);
				endcase
			end
			LAYOUT_TWO: step = idx_q[0] ? 18'sd25736 : 18'sd0;
			default: begin
				case (idx_q)
					2'd0: step = 18'sd0;
					2'd1: step = 18'sd12868;
					2'd2: step = 18'sd25736;
					default: step = 18'sd38604;
				endcase
			end
		endcase
		a_raw = 18'(yaw_q) + step;
		// Sum lies within (-3pi, 3pi), so at most one correction each way.
		if (a_raw > 18'(PiQ)) begin
			a_w = a_raw - TwoPiQ;
		end else if (a_raw <= -18'(PiQ)) begin
			a_w = a_raw + TwoPiQ;
		end else begin
			a_w = a_raw;
		end
		if (lay_q == LAYOUT_THREE) begin
			case (idx_q)
				2'd0: dz = '0;
				2'd1: dz = 25'(ht_q);
				default: dz = 25'(ah_q);
			endcase
		end else begin
			dz = alt ? 25'(ht_q) + 25'(ah_q) : 25'(ht_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == last_q) begin
					busy_q <= 1'b0;
				end
			end
			if (issue) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			lay_q <= lay_in;
			last_q <= last_in;
			cx_q <= center_x;
			cy_q <= center_y;
			cz_q <= center_z;
			yaw_q <= yaw_angle;
			r0_q <= ring_radius;
			r1_q <= alt_radius;
			ht_q <= height_term;
			ah_q <= alt_height_offset;
		end
		if (issue) begin
			plate_s1.cx <= cx_q;
			plate_s1.cy <= cy_q;
			plate_s1.pz <= sat_pos(26'(cz_q) + 26'(dz));
			plate_s1.ang <= a_w[AngW-1:0];
			plate_s1.rad <= alt ? r1_q : r0_q;
			plate_s1.outward <= (lay_q == LAYOUT_THREE);
			plate_s1.idx <= idx_q;
			plate_s1.last <= (idx_q == last_q);
		end
	end

endmodule

[hdl/arp_cordic.sv]
// Unrolled, registered rotation-mode CORDIC stages carrying plate payload.
// Depends on arp_pkg.
module arp_cordic import arp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic vld_s1,
	input  plate_t plate_s1,
	output logic vld_s2,
	output plate_t plate_s2,
	output logic signed [CordW-1:0] cos_s2,
	output logic signed [CordW-1:0] sin_s2
);

	logic signed [CordW-1:0] x_q [CordicSteps+1];
	logic signed [CordW-1:0] y_q [CordicSteps+1];
	logic signed [ZW-1:0] z_q [CordicSteps+1];
	logic neg_q [CordicSteps+1];
	logic v_q [CordicSteps+1];
	plate_t p_q [CordicSteps+1];

	logic signed [AngW-1:0] a_fold;
	logic neg0;

	always_comb begin
		neg0 = 1'b0;
		a_fold = plate_s1.ang;
		if (plate_s1.ang > HalfPiQ) begin
			a_fold = plate_s1.ang - PiQ;
			neg0 = 1'b1;
		end else if (plate_s1.ang < -HalfPiQ) begin
			a_fold = plate_s1.ang + PiQ;
			neg0 = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= CordicSteps; i++) begin
				v_q[i] <= 1'b0;
			end
		end else if (adv) begin
			v_q[0] <= vld_s1;
			for (int i = 1; i <= CordicSteps; i++) begin
				v_q[i] <= v_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_q[0] <= CordicGain;
			y_q[0] <= '0;
			z_q[0] <= {{(ZW-AngW-15){a_fold[AngW-1]}}, a_fold, 15'd0};
			neg_q[0] <= neg0;
			p_q[0] <= plate_s1;
			for (int i = 0; i < CordicSteps; i++) begin
				if (!z_q[i][ZW-1]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_q(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_q(i);
				end
				neg_q[i+1] <= neg_q[i];
				p_q[i+1] <= p_q[i];
			end
		end
	end

	assign vld_s2 = v_q[CordicSteps];
	assign plate_s2 = p_q[CordicSteps];
	assign cos_s2 = neg_q[CordicSteps] ? -x_q[CordicSteps] : x_q[CordicSteps];
	assign sin_s2 = neg_q[CordicSteps] ? -y_q[CordicSteps] : y_q[CordicSteps];

endmodule

[hdl/arp_place.sv]
// Scales cos/sin by the radius, offsets from the centre and saturates.
// Depends on arp_pkg.
module arp_place import arp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic vld_s2,
	input  plate_t plate_s2,
	input  logic signed [CordW-1:0] cos_s2,
	input  logic signed [CordW-1:0] sin_s2,
	output logic vld_s4,
	output plate_t plate_s4,
	output logic signed [PosW-1:0] px_s4,
	output logic signed [PosW-1:0] py_s4
);

	logic vld_s3;
	plate_t plate_s3;
	logic signed [ProdW-1:0] pc_s3, ps_s3;
	logic signed [ProdW-1:0] rc, rs;
	logic signed [PosW+1:0] dx, dy, sx, sy;

	always_comb begin
		rc = (pc_s3 + (ProdW'(1) <<< 29)) >>> 30;
		rs = (ps_s3 + (ProdW'(1) <<< 29)) >>> 30;
		dx = rc[PosW+1:0];
		dy = rs[PosW+1:0];
		if (plate_s3.outward) begin
			sx = 26'(plate_s3.cx) + dx;
			sy = 26'(plate_s3.cy) + dy;
		end else begin
			sx = 26'(plate_s3.cx) - dx;
			sy = 26'(plate_s3.cy) - dy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pc_s3 <= $signed({1'b0, plate_s2.rad}) * cos_s2;
			ps_s3 <= $signed({1'b0, plate_s2.rad}) * sin_s2;
			plate_s3 <= plate_s2;
			plate_s4 <= plate_s3;
			px_s4 <= sat_pos(sx);
			py_s4 <= sat_pos(sy);
		end
	end

endmodule

[hdl/armor_ring_positions.sv]
// Top level of the armor ring position block: config registers and pipeline.
// Depends on arp_pkg, arp_sequencer, arp_cordic and arp_place.
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  one target estimate
// output    out        out_valid/ out_stall one plate position per transaction
// config    in         cfg_we               cfg_index, cfg_data
//
// One estimate yields one to four plates, issued one per cycle while the output
// does not stall. The estimate is taken first and its plates are issued after it;
// the input stays stalled until the last plate of the estimate has been issued.
// Each plate then passes one folding stage, CordicSteps CORDIC stages and two
// placement stages. Reset clears the valid bits and restores the register
// defaults. A stall on the output freezes the CORDIC and placement stages, but
// an empty issue register can still be filled. The next estimate is taken in
// the cycle after the last plate of the previous one is issued.
module armor_ring_positions import arp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [PosW-1:0] center_x,
	input  logic signed [PosW-1:0] center_y,
	input  logic signed [PosW-1:0] center_z,
	input  logic signed [AngW-1:0] yaw_angle,
	input  logic [RadW-1:0] ring_radius,
	input  logic [RadW-1:0] alt_radius,
	input  logic signed [PosW-1:0] height_term,
	input  logic signed [PosW-1:0] alt_height_offset,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [PosW-1:0] plate_x,
	output logic signed [PosW-1:0] plate_y,
	output logic signed [PosW-1:0] plate_z,
	output logic signed [AngW-1:0] plate_angle,
	output logic [1:0] plate_index,
	output logic final_plate,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);

	logic [2:0] cnt_q;
	logic calib_q;
	logic signed [AngW-1:0] offs0_q, offs1_q, offs2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd4;
			calib_q <= 1'b0;
			offs0_q <= 16'sd0;
			offs1_q <= 16'sd17157;
			offs2_q <= -16'sd17157;
		end else if (cfg_we) begin
			case (cfg_index)
				IdxCount: cnt_q <= cfg_data[2:0];
				IdxCalib: calib_q <= cfg_data[0];
				IdxOffs0: offs0_q <= cfg_data;
				IdxOffs1: offs1_q <= cfg_data;
				IdxOffs2: offs2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together unless a held result is stalled.
	logic adv;
	assign adv = !(out_valid && out_stall);

	logic vld_s1, vld_s2;
	plate_t plate_s1, plate_s2, plate_s4;
	logic signed [CordW-1:0] cos_s2, sin_s2;

	arp_sequencer u_seq (
		.clk, .arst_n, .in_valid, .in_stall,
		.center_x, .center_y, .center_z, .yaw_angle,
		.ring_radius, .alt_radius, .height_term, .alt_height_offset,
		.cnt_cfg(cnt_q), .calib_cfg(calib_q),
		.offs0_cfg(offs0_q), .offs1_cfg(offs1_q), .offs2_cfg(offs2_q),
		.adv, .vld_s1, .plate_s1
	);

	arp_cordic u_cordic (
		.clk, .arst_n, .adv, .vld_s1, .plate_s1,
		.vld_s2, .plate_s2, .cos_s2, .sin_s2
	);

	arp_place u_place (
		.clk, .arst_n, .adv, .vld_s2, .plate_s2, .cos_s2, .sin_s2,
		.vld_s4(out_valid), .plate_s4, .px_s4(plate_x), .py_s4(plate_y)
	);

	assign plate_z = plate_s4.pz;
	assign plate_angle = plate_s4.ang;
	assign plate_index = plate_s4.idx;
	assign final_plate = plate_s4.last;

	// A stalled result must hold.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(plate_index))
		else $error("result changed under stall");

	// Angles leave wrapped.
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (plate_angle <= PiQ) && (plate_angle > -PiQ))
		else $error("angle out of range");

	// The input side is only free when no estimate is being issued.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("estimate taken without issuing");

endmodule

[tb/testbench.sv]
// Self-checking testbench for armor_ring_positions: drives target estimates,
// predicts every plate position and compares the block's plate transactions.
// Depends on arp_pkg and the armor_ring_positions RTL.
`timescale 1ns / 1ps

module testbench;
	import arp_pkg::*;

	// One target estimate as the sender offers it.
	typedef struct {
		logic signed [PosW-1:0] cx;
		logic signed [PosW-1:0] cy;
		logic signed [PosW-1:0] cz;
		logic signed [AngW-1:0] yaw;
		logic [RadW-1:0] r0;
		logic [RadW-1:0] r1;
		logic signed [PosW-1:0] ht;
		logic signed [PosW-1:0] ah;
	} estimate_t;

	// One predicted plate position.
	typedef struct {
		logic signed [PosW-1:0] x;
		logic signed [PosW-1:0] y;
		logic signed [PosW-1:0] z;
		logic signed [AngW-1:0] ang;
		logic [1:0] idx;
		logic last;
	} plate_pos_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [PosW-1:0] center_x = '0;
	logic signed [PosW-1:0] center_y = '0;
	logic signed [PosW-1:0] center_z = '0;
	logic signed [AngW-1:0] yaw_angle = '0;
	logic [RadW-1:0] ring_radius = '0;
	logic [RadW-1:0] alt_radius = '0;
	logic signed [PosW-1:0] height_term = '0;
	logic signed [PosW-1:0] alt_height_offset = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [PosW-1:0] plate_x;
	logic signed [PosW-1:0] plate_y;
	logic signed [PosW-1:0] plate_z;
	logic signed [AngW-1:0] plate_angle;
	logic [1:0] plate_index;
	logic final_plate;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	armor_ring_positions uut (.*);

	// Estimates waiting to be offered, and plate positions waiting to arrive.
	estimate_t pending_estimates[$];
	plate_pos_t expected_plates[$];
	int errors = 0;

	// The testbench's own copy of the configuration registers.
	logic [2:0] plate_count_reg = 3'd4;
	logic calibrated_reg = 1'b0;
	logic signed [AngW-1:0] offset_reg [3] = '{16'sd0, 16'sd17157, -16'sd17157};

	// Idling percentages, and the long receiver hold-off request.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	// Arctangent of 2^-i in Q4.28 radians.
	localparam longint AtanQ28 [24] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
		4193963, 2097109, 1048571, 524287, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048,
		1024, 512, 256, 128, 64, 32
	};

	initial begin
		forever #5 clk = ~clk;
	end

	// Rotation-mode CORDIC on a wrapped Q3.13 angle; cosine and sine in Q1.30.
	// Angles beyond a quarter turn are folded by half a turn and negated after.
	function automatic void rotate_unit(input longint ang, output longint c,
			output longint s);
		longint x, y, z, dx, dy;
		bit flip;
		x = longint'(CordicGain);
		y = 0;
		flip = 0;
		if (ang > HalfPiQ) begin
			ang -= PiQ;
			flip = 1;
		end else if (ang < -HalfPiQ) begin
			ang += PiQ;
			flip = 1;
		end
		z = ang * 32768;
		for (int i = 0; i < CordicSteps && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= AtanQ28[i];
			end else begin
				x += dx;
				y -= dy;
				z += AtanQ28[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint round_product(input longint r, input longint t);
		return (r * t + (longint'(1) << 29)) >>> 30;
	endfunction

	function automatic logic signed [PosW-1:0] clamp_pos(input longint v);
		if (v > 8388607) return PosMax;
		if (v < -8388608) return PosMin;
		return v[PosW-1:0];
	endfunction

	// Works out every plate of one accepted estimate and queues them.
	function automatic void predict_plates(input estimate_t e);
		longint n, a, r, dz, c, s, px, py;
		int shown;
		bit alt;
		plate_pos_t p;
		n = longint'(plate_count_reg);
		if (n < 2) n = 2;
		if (n > 4) n = 4;
		shown = int'(n);
		if (n == 3 && !calibrated_reg) shown = 1;
		for (int i = 0; i < shown; i++) begin
			alt = (n == 4) && (i % 2 == 1);
			if (n == 3) a = longint'(e.yaw) + longint'(offset_reg[i]);
			else a = longint'(e.yaw) + (i * 51472) / n;
			while (a > 25736) a -= 51472;
			while (a <= -25736) a += 51472;
			r = alt ? longint'(e.r1) : longint'(e.r0);
			dz = alt ? longint'(e.ht) + longint'(e.ah) : longint'(e.ht);
			if (n == 3) dz = (i == 0) ? 0 : ((i == 1) ? longint'(e.ht) : longint'(e.ah));
			rotate_unit(a, c, s);
			if (n == 3) begin
				px = longint'(e.cx) + round_product(r, c);
				py = longint'(e.cy) + round_product(r, s);
			end else begin
				px = longint'(e.cx) - round_product(r, c);
				py = longint'(e.cy) - round_product(r, s);
			end
			p.x = clamp_pos(px);
			p.y = clamp_pos(py);
			p.z = clamp_pos(longint'(e.cz) + dz);
			p.ang = a[AngW-1:0];
			p.idx = i[1:0];
			p.last = (i == shown - 1);
			expected_plates = {expected_plates, p};
		end
	endfunction

	// Appends one estimate to the end of the pending queue.
	task automatic queue_estimate(input estimate_t e);
		pending_estimates = {pending_estimates, e};
	endtask

	// Driver: the current estimate stays on the port until its transaction
	// completes; only then is the next one taken from the pending queue, or
	// the port goes idle at the chosen rate.
	estimate_t on_port;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) predict_plates(on_port);
			if (!in_valid || !in_stall) begin
				if (pending_estimates.size() > 0 &&
						$urandom_range(99) >= send_idle_pct) begin
					on_port = pending_estimates.pop_front();
					center_x <= on_port.cx;
					center_y <= on_port.cy;
					center_z <= on_port.cz;
					yaw_angle <= on_port.yaw;
					ring_radius <= on_port.r0;
					alt_radius <= on_port.r1;
					height_term <= on_port.ht;
					alt_height_offset <= on_port.ah;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each plate transaction against the oldest prediction and
	// chooses the stall for the next cycle. A long hold-off keeps the stall up
	// for a counted stretch so that the pipeline fills and stalls its input.
	always @(posedge clk) begin
		plate_pos_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_plates.size() == 0) begin
					$display("%0t: unexpected plate transaction, index %0d", $realtime,
						plate_index);
					errors++;
				end else begin
					want = expected_plates.pop_front();
					if (plate_x !== want.x) begin
						$display("%0t: plate_x expected %0d actual %0d", $realtime,
							want.x, plate_x);
						errors++;
					end
					if (plate_y !== want.y) begin
						$display("%0t: plate_y expected %0d actual %0d", $realtime,
							want.y, plate_y);
						errors++;
					end
					if (plate_z !== want.z) begin
						$display("%0t: plate_z expected %0d actual %0d", $realtime,
							want.z, plate_z);
						errors++;
					end
					if (plate_angle !== want.ang) begin
						$display("%0t: plate_angle expected %0d actual %0d", $realtime,
							want.ang, plate_angle);
						errors++;
					end
					if (plate_index !== want.idx) begin
						$display("%0t: plate_index expected %0d actual %0d", $realtime,
							want.idx, plate_index);
						errors++;
					end
					if (final_plate !== want.last) begin
						$display("%0t: final_plate expected %0b actual %0b", $realtime,
							want.last, final_plate);
						errors++;
					end
				end
			end
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left = 200;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Writes one register while the block is idle and mirrors it locally.
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			IdxCount: plate_count_reg = value[2:0];
			IdxCalib: calibrated_reg = value[0];
			IdxOffs0: offset_reg[0] = value;
			IdxOffs1: offset_reg[1] = value;
			IdxOffs2: offset_reg[2] = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// The sender pauses here until every predicted plate has arrived, then
	// lets the pipeline drain before anything else happens.
	task automatic wait_drained();
		while (pending_estimates.size() > 0 || in_valid || expected_plates.size() > 0)
			@(posedge clk);
		repeat (CordicSteps + 8) @(posedge clk);
	endtask

	function automatic estimate_t make_estimate(input longint cx, input longint cy,
			input longint cz, input longint yaw, input longint r0, input longint r1,
			input longint ht, input longint ah);
		estimate_t e;
		e.cx = cx[PosW-1:0];
		e.cy = cy[PosW-1:0];
		e.cz = cz[PosW-1:0];
		e.yaw = yaw[AngW-1:0];
		e.r0 = r0[RadW-1:0];
		e.r1 = r1[RadW-1:0];
		e.ht = ht[PosW-1:0];
		e.ah = ah[PosW-1:0];
		return e;
	endfunction

	// Mostly realistic geometry (a few metres), sometimes any bit pattern at all.
	function automatic estimate_t random_estimate();
		estimate_t e;
		e.cx = PosW'($urandom);
		e.cy = PosW'($urandom);
		e.cz = PosW'($urandom);
		e.yaw = AngW'($urandom);
		e.r0 = RadW'($urandom);
		e.r1 = RadW'($urandom);
		e.ht = PosW'($urandom);
		e.ah = PosW'($urandom);
		if ($urandom_range(3) != 0) begin
			e.cx = $signed(24'($urandom_range(1310720))) - 24'sd655360;
			e.cy = $signed(24'($urandom_range(1310720))) - 24'sd655360;
			e.cz = $signed(24'($urandom_range(262144))) - 24'sd131072;
			e.r0 = RadW'($urandom_range(65536));
			e.r1 = RadW'($urandom_range(65536));
			e.ht = $signed(24'($urandom_range(65536))) - 24'sd32768;
			e.ah = $signed(24'($urandom_range(65536))) - 24'sd32768;
		end
		return e;
	endfunction

	task automatic run_random(input int count, input int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0; recv_stall_pct = 0; end
			1: begin send_idle_pct = 77; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 77; end
			default: begin send_idle_pct = 36; recv_stall_pct = 36; end
		endcase
		for (int i = 0; i < count; i++) queue_estimate(random_estimate());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset configuration (four plates): field
		// extremes, wrap-around of the yaw, and saturation of every position.
		queue_estimate(make_estimate(0, 0, 0, 0, 65536, 32768, 0, 0));
		queue_estimate(make_estimate(0, 0, 0, -32768, 65536, 65536, 100, 200));
		queue_estimate(make_estimate(0, 0, 0, 32767, 65536, 65536, -100, 50));
		queue_estimate(make_estimate(1, 2, 3, 25736, 1000, 2000, 7, 9));
		queue_estimate(make_estimate(1, 2, 3, -25736, 1000, 2000, 7, 9));
		queue_estimate(make_estimate(5, 5, 5, 12868, 70000, 80000, 1, 1));
		queue_estimate(make_estimate(5, 5, 5, -12868, 70000, 80000, 1, 1));
		queue_estimate(make_estimate(8388607, 8388607, 8388607, 0,
			8388607, 8388607, 8388607, 8388607));
		queue_estimate(make_estimate(-8388608, -8388608, -8388608, 12868,
			8388607, 8388607, -8388608, -8388608));
		queue_estimate(make_estimate(-8388608, 8388607, 0, -20000,
			0, 0, 8388607, -8388608));
		queue_estimate(make_estimate(0, 0, 0, 1, 8388607, 0, 0, 0));
		queue_estimate(make_estimate(-1, -1, -1, -1, 1, 1, -1, -1));
		wait_drained();

		// Three plates, both calibrated states, offsets at the wrap limits.
		write_reg(IdxCount, 16'hFFF8 | 16'd3);
		write_reg(IdxCalib, 16'd0);
		queue_estimate(make_estimate(100, 200, 300, 32767, 65536, 0, 5, 6));
		queue_estimate(make_estimate(100, 200, 300, -32768, 65536, 0, 5, 6));
		wait_drained();
		write_reg(IdxCalib, 16'hFFFF);
		write_reg(IdxOffs0, 16'd25736);
		write_reg(IdxOffs1, -16'sd25736);
		write_reg(IdxOffs2, 16'd0);
		queue_estimate(make_estimate(100, 200, 300, 32767, 65536, 9, 5, 6));
		queue_estimate(make_estimate(100, 200, 300, -32768, 65536, 9, 5, 6));
		queue_estimate(make_estimate(8388607, -8388608, 8388607, 25736,
			8388607, 0, 8388607, 8388607));
		wait_drained();

		// Out-of-range plate counts act as the nearest legal layout.
		write_reg(IdxCount, 16'd0);
		queue_estimate(make_estimate(0, 0, 0, 25000, 65536, 0, 1, 2));
		wait_drained();
		write_reg(IdxCount, 16'd1);
		queue_estimate(make_estimate(0, 0, 0, -25000, 65536, 0, 1, 2));
		wait_drained();
		write_reg(IdxCount, 16'd5);
		queue_estimate(make_estimate(0, 0, 0, 20000, 65536, 30000, 1, 2));
		wait_drained();
		write_reg(IdxCount, 16'd7);
		queue_estimate(make_estimate(0, 0, 0, -20000, 65536, 30000, 1, 2));
		wait_drained();

		// Random part: a sequence of settings, each with its own idling mode.
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 6)
				0: write_reg(IdxCount, 16'd2);
				1: write_reg(IdxCount, 16'd4);
				2: begin
					write_reg(IdxCount, 16'd3);
					write_reg(IdxCalib, 16'd0);
				end
				3: begin
					write_reg(IdxCount, 16'd3);
					write_reg(IdxCalib, 16'd1);
					write_reg(IdxOffs0, 16'($signed(16'($urandom_range(51472))) - 16'sd25736));
					write_reg(IdxOffs1, 16'($signed(16'($urandom_range(51472))) - 16'sd25736));
					write_reg(IdxOffs2, 16'($signed(16'($urandom_range(51472))) - 16'sd25736));
				end
				4: begin
					write_reg(IdxCount, 16'd3);
					write_reg(IdxCalib, 16'd1);
					write_reg(IdxOffs0, -16'sd25736);
					write_reg(IdxOffs1, 16'd25736);
					write_reg(IdxOffs2, 16'd17157);
				end
				default: write_reg(IdxCount, 16'($urandom_range(7)));
			endcase
			run_random(38, ph);
			// Once in a while the receiver holds off for a long stretch while
			// the sender keeps offering estimates.
			if (ph % 4 == 2) begin
				@(posedge clk);
				hold_requests++;
			end
			wait_drained();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_drained();
		if (errors == 0 && expected_plates.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
hdl/arp_pkg.sv
hdl/arp_sequencer.sv
hdl/arp_cordic.sv
hdl/arp_place.sv
hdl/armor_ring_positions.sv
tb/testbench.sv
